### src/fgb_pkg.sv
// Shared types and constants of the font glyph blitter.
package fgb_pkg;

    localparam int GLYPH_SIZE  = 8;
    localparam int SHEET_WIDTH = 128;
    localparam int SHEET_BYTES = SHEET_WIDTH * SHEET_WIDTH;
    localparam int SHEET_IDX_W = $clog2(SHEET_BYTES);
    localparam int GLYPH_IDX_W = $clog2(GLYPH_SIZE);
    localparam int OUT_ADDR_W  = 24;
    localparam int BASE_W      = 24;
    localparam int STRIDE_W    = 13;
    localparam int POS_X_W     = 11;
    localparam int POS_Y_W     = 12;
    localparam int CODE_W      = 8;
    localparam int PIXEL_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 1'b1;

    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RESET = 13'd320;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROD,
        ST_ROWINIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic load;
        logic prod;
        logic row_init;
        logic issue;
    } t_cmd;

    typedef struct packed {
        logic in_draw;
        logic in_visible;
        logic out_free;
        logic glyph_end;
    } t_status;

endpackage

### src/fgb_ctrl.sv
// Controller state machine of the font glyph blitter.
module fgb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fgb_pkg::t_status i_status,
    output fgb_pkg::t_cmd    o_cmd
);
    import fgb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_status.in_draw) begin
                        o_cmd.load = 1'b1;
                    end else if (i_status.in_visible) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_PROD;
                    end
                end
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = ST_ROWINIT;
            end
            ST_ROWINIT: begin
                o_cmd.row_init = 1'b1;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.issue = 1'b1;
                    if (i_status.glyph_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/fgb_datapath.sv
// Datapath of the font glyph blitter: font sheet memory, counters, address and output stage.
module fgb_datapath #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  fgb_pkg::t_cmd                           i_cmd,
    output fgb_pkg::t_status                        o_status,
    input  logic                                    i_cfg_wr_en,
    input  logic [fgb_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [fgb_pkg::CFG_DATA_W-1:0]          i_cfg_wdata,
    input  logic                                    i_operation,
    input  logic [fgb_pkg::SHEET_IDX_W-1:0]         i_sheet_index,
    input  logic [fgb_pkg::PIXEL_W-1:0]             i_sheet_byte,
    input  logic [fgb_pkg::CODE_W-1:0]              i_char_code,
    input  logic [fgb_pkg::POS_X_W-1:0]             i_pos_x,
    input  logic signed [fgb_pkg::POS_Y_W-1:0]      i_pos_y,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [fgb_pkg::OUT_ADDR_W-1:0]          o_write_address,
    output logic [fgb_pkg::PIXEL_W-1:0]             o_color,
    output logic                                    o_write_enable,
    output logic                                    o_last
);
    import fgb_pkg::*;

    // addresses wrap at 2^min(ADDRESS_BITS, 24) and are then zero-extended to 24 bits
    localparam int AW = (ADDRESS_BITS < OUT_ADDR_W) ? ADDRESS_BITS : OUT_ADDR_W;
    localparam int NIB_W = CODE_W / 2;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_LAST = GLYPH_IDX_W'(GLYPH_SIZE - 1);

    logic [PIXEL_W-1:0]     r_sheet [SHEET_BYTES];

    logic [BASE_W-1:0]      r_frame_base;
    logic [STRIDE_W-1:0]    r_row_stride;

    logic [NIB_W-1:0]       r_grow;
    logic [NIB_W-1:0]       r_gcol;
    logic [GLYPH_IDX_W-1:0] r_srow;
    logic [GLYPH_IDX_W-1:0] r_col;
    logic [POS_X_W-2+1:0]   r_pos_x;
    logic [POS_Y_W-2:0]     r_ypos;
    logic [OUT_ADDR_W-1:0]  r_prod;
    logic [AW-1:0]          r_row_addr;

    logic                   r_out_valid;
    logic [AW-1:0]          r_out_addr;
    logic [PIXEL_W-1:0]     r_out_color;
    logic                   r_out_last;

    logic                   w_neg;
    logic [GLYPH_IDX_W-1:0] w_first;
    logic [POS_Y_W-1:0]     w_neg_y;
    logic [SHEET_IDX_W-1:0] w_rd_idx;
    logic                   w_glyph_end;

    assign w_neg       = i_pos_y[POS_Y_W-1];
    assign w_neg_y     = POS_Y_W'(-i_pos_y);
    assign w_first     = w_neg ? w_neg_y[GLYPH_IDX_W-1:0] : '0;
    assign w_rd_idx    = {r_grow, r_srow, r_gcol, r_col};
    assign w_glyph_end = (r_srow == GLYPH_LAST) && (r_col == GLYPH_LAST);

    assign o_status.in_draw    = (i_operation == OP_DRAW);
    assign o_status.in_visible = (i_pos_y > -12'sd8);
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.glyph_end  = w_glyph_end;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
            r_row_stride <= ROW_STRIDE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_BASE: r_frame_base <= i_cfg_wdata[BASE_W-1:0];
                CFG_ROW_STRIDE: r_row_stride <= i_cfg_wdata[STRIDE_W-1:0];
                default:        r_frame_base <= r_frame_base;
            endcase
        end
    end

    // font sheet: one write port for loads, registered read for pixels
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sheet[i_sheet_index] <= i_sheet_byte;
        end
        if (i_cmd.issue) begin
            r_out_color <= r_sheet[w_rd_idx];
        end
    end

    // glyph walk: capture, stride multiply, row address set-up, then one pixel per issue
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_grow  <= i_char_code[CODE_W-1:NIB_W];
            r_gcol  <= i_char_code[NIB_W-1:0];
            r_srow  <= w_first;
            r_col   <= '0;
            r_pos_x <= i_pos_x;
            r_ypos  <= w_neg ? '0 : i_pos_y[POS_Y_W-2:0];
        end
        if (i_cmd.prod) begin
            r_prod <= OUT_ADDR_W'(r_ypos) * OUT_ADDR_W'(r_row_stride);
        end
        if (i_cmd.row_init) begin
            r_row_addr <= r_frame_base[AW-1:0] + r_prod[AW-1:0] + AW'(r_pos_x);
        end
        if (i_cmd.issue) begin
            r_out_addr <= r_row_addr + AW'(r_col);
            r_out_last <= w_glyph_end;
            if (r_col == GLYPH_LAST) begin
                r_col      <= '0;
                r_srow     <= r_srow + 1'b1;
                r_row_addr <= r_row_addr + AW'(r_row_stride);
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = OUT_ADDR_W'(r_out_addr);
    assign o_color         = r_out_color;
    assign o_write_enable  = (r_out_color != '0);
    assign o_last          = r_out_last;

endmodule

### src/font_glyph_blitter.sv
// Top level of the font glyph blitter: 8x8 glyph expansion into frame buffer writes.
//
// Input channel (i_in_valid / o_in_ready): one transaction is either a load,
// which stores one byte of the 128x128-byte font sheet, or a draw, which
// expands the 8x8 glyph of i_char_code at (i_pos_x, i_pos_y).
// Output channel (o_out_valid / i_out_ready): one transaction per glyph pixel,
// row by row and left to right, with o_last on the final pixel. Transparent
// pixels come out with o_write_enable low rather than being dropped.
// Configuration: i_cfg_wr_en writes frame base (index 0) or row stride
// (index 1); write only while the blitter is idle.
// Timing: a load is taken in the idle state. A draw passes its acceptance,
// two set-up steps (stride multiply, row address) and then issues one pixel
// per cycle while the output register is free, holding the input channel
// until the last pixel is issued. Each pixel is read through the single read
// port of the font sheet memory.
// A draw with the glyph entirely above the screen yields nothing and is
// taken without leaving the idle state.
// Reset clears the controller, the output valid and the configuration
// registers (base 0, stride 320); the font sheet is undefined until loaded.
// When the receiver stalls, the output register holds its pixel and the walk
// pauses; the next input transaction is taken once the last pixel is issued.
module font_glyph_blitter #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [fgb_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [fgb_pkg::CFG_DATA_W-1:0]          i_cfg_wdata,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_operation,
    input  logic [fgb_pkg::SHEET_IDX_W-1:0]         i_sheet_index,
    input  logic [fgb_pkg::PIXEL_W-1:0]             i_sheet_byte,
    input  logic [fgb_pkg::CODE_W-1:0]              i_char_code,
    input  logic [fgb_pkg::POS_X_W-1:0]             i_pos_x,
    input  logic signed [fgb_pkg::POS_Y_W-1:0]      i_pos_y,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [fgb_pkg::OUT_ADDR_W-1:0]          o_write_address,
    output logic [fgb_pkg::PIXEL_W-1:0]             o_color,
    output logic                                    o_write_enable,
    output logic                                    o_last
);
    import fgb_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequence the draw: capture, multiply, row set-up, pixel walk
    fgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // hold the font sheet, compute addresses and drive the output register
    fgb_datapath #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_operation),
        .i_sheet_index   (i_sheet_index),
        .i_sheet_byte    (i_sheet_byte),
        .i_char_code     (i_char_code),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_write_address (o_write_address),
        .o_color         (o_color),
        .o_write_enable  (o_write_enable),
        .o_last          (o_last)
    );

endmodule
